FILE: sv/sha512_pkg.sv
// Package: shared types, constants and round functions for the SHA-512 engine.
package sha512_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned Rounds   = 80;
  localparam int unsigned BlkWords = 16;
  localparam logic [7:0]  PadMark  = 8'h80;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_word;   // write incoming request word, count bytes
    logic load_last;   // incoming word is the last one
    logic start_comp;  // begin 80-round compression
    logic round_en;    // run one round
    logic finish_comp; // fold working vars into chaining value
    logic pad_push;    // write one padding word
    logic emit_clear;  // reset hash state after digest is out
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic buf_full;    // sixteen words present
    logic round_done;  // all rounds applied, fold pending
    logic pad_done;    // length words written
    logic pad_busy;    // message closed, padding or digest pending
  } dp_sts_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0:    init_hash = 64'h6a09e667f3bcc908;
      3'd1:    init_hash = 64'hbb67ae8584caa73b;
      3'd2:    init_hash = 64'h3c6ef372fe94f82b;
      3'd3:    init_hash = 64'ha54ff53a5f1d36f1;
      3'd4:    init_hash = 64'h510e527fade682d1;
      3'd5:    init_hash = 64'h9b05688c2b3e6c1f;
      3'd6:    init_hash = 64'h1f83d9abfb41bd6b;
      default: init_hash = 64'h5be0cd19137e2179;
    endcase
  endfunction

  function automatic word_t round_k(input logic [6:0] i);
    case (i)
      7'd0:  round_k = 64'h428a2f98d728ae22; 7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f; 7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538; 7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b; 7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242; 7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage

FILE: sv/sha512_hash_engine.sv
// SHA-512 engine: one word per cycle into a 16-word buffer while idle and not full; a full
// buffer is then compressed by 80 rounds on a single round unit plus one fold into the
// chaining value, with no word taken meanwhile. A last word adds one or two padded blocks,
// then the eight digest words come out one per accepted cycle, index 0 first.
module sha512_hash_engine
  import sha512_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_message_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [2:0] idx;

  sha512_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_last),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .out_idx(idx), .cmd(cmd), .sts(sts)
  );

  sha512_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_word(in_message_word),
    .in_vb(in_valid_bytes), .sts(sts), .emit_idx(idx), .emit_word(out_digest_word)
  );

  assign out_word_index = idx;
  assign out_final_word = (idx == 3'd7);

endmodule

FILE: sv/sha512_dp.sv
// Datapath: block buffer, message schedule, round unit, chaining value, byte count.
module sha512_dp
  import sha512_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  word_t      in_word,
  input  logic [3:0] in_vb,
  output dp_sts_t    sts,
  input  logic [2:0] emit_idx,
  output word_t      emit_word
);

  // the schedule window doubles as the block buffer: slot 0 holds W[t]
  word_t       w_r [BlkWords];
  word_t       w_nxt [BlkWords];
  word_t       h_r [8];
  word_t       v_r [8];
  logic [4:0]  fill_r, fill_nxt;      // words in buffer, 0..16
  logic [6:0]  rnd_r;
  logic [127:0] cnt_r, cnt_nxt;
  // 0: zeros/length high pending, 1: mark pending, 2: length low pending, 3: length done
  logic [1:0]  pad_ph_r, pad_ph_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic [127:0] bits_len;
  word_t       push_word;
  logic        do_push;
  logic [3:0]  vb;
  word_t       keep;
  word_t       wlast;
  word_t       t1, t2, s0, s1, e, a, wn;

  assign bits_len = cnt_r << 3;
  assign vb = (in_vb > 4'd8) ? 4'd8 : in_vb;

  always_comb begin
    keep = (vb == 4'd0) ? '0 : ~(64'(0) - 64'(0)) << (7'd64 - {vb, 3'b000});
    wlast = (in_word & keep) | (word_t'(PadMark) << (7'd56 - {vb, 3'b000}));
  end

  // pick the word written this cycle and the counter and padding-phase update
  always_comb begin
    do_push = 1'b0;
    push_word = in_word;
    cnt_nxt = cnt_r;
    pad_ph_nxt = pad_ph_r;
    pad_act_nxt = pad_act_r;
    if (cmd.load_word) begin
      do_push = 1'b1;
      if (!cmd.load_last) begin
        cnt_nxt = cnt_r + 128'd8;
      end else begin
        cnt_nxt = cnt_r + 128'(vb);
        pad_act_nxt = 1'b1;
        if (vb == 4'd8) begin
          pad_ph_nxt = 2'd1;
        end else begin
          push_word = wlast;
          pad_ph_nxt = 2'd0;
        end
      end
    end else if (cmd.pad_push) begin
      do_push = 1'b1;
      if (pad_ph_r == 2'd1) begin
        push_word = {PadMark, 56'd0};
        pad_ph_nxt = 2'd0;
      end else if (pad_ph_r == 2'd2) begin
        push_word = bits_len[63:0];
        pad_ph_nxt = 2'd3;
      end else if (fill_r == 5'd14) begin
        push_word = bits_len[127:64];
        pad_ph_nxt = 2'd2;
      end else begin
        push_word = '0;
      end
    end
    if (cmd.emit_clear) begin
      cnt_nxt = '0;
      pad_act_nxt = 1'b0;
      pad_ph_nxt = 2'd0;
    end
  end

  // length goes in only when two slots remain; controller pads after a compress
  assign sts.buf_full   = (fill_r == 5'd16);
  assign sts.round_done = (rnd_r == 7'(Rounds));
  assign sts.pad_done   = (pad_ph_r == 2'd3);
  assign sts.pad_busy   = pad_act_r;

  assign fill_nxt = cmd.start_comp ? 5'd0 : (do_push ? fill_r + 5'd1 : fill_r);

  always_comb begin
    a  = v_r[0];
    e  = v_r[4];
    s0 = rotr(w_r[1], 1) ^ rotr(w_r[1], 8) ^ (w_r[1] >> 7);
    s1 = rotr(w_r[14], 19) ^ rotr(w_r[14], 61) ^ (w_r[14] >> 6);
    wn = s1 + w_r[9] + s0 + w_r[0];
    t1 = v_r[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & v_r[5]) ^ (~e & v_r[6]))
         + round_k(rnd_r) + w_r[0];
    t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
         + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    for (int i = 0; i < BlkWords; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (cmd.round_en) begin
      for (int i = 0; i < BlkWords - 1; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[BlkWords-1] = wn;
    end else if (do_push) begin
      w_nxt[fill_r[3:0]] = push_word;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BlkWords; i++) begin
      w_r[i] <= w_nxt[i];
    end
    if (cmd.start_comp) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      rnd_r     <= '0;
      cnt_r     <= '0;
      pad_ph_r  <= '0;
      pad_act_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= init_hash(3'(i));
      end
    end else begin
      fill_r    <= fill_nxt;
      cnt_r     <= cnt_nxt;
      pad_ph_r  <= pad_ph_nxt;
      pad_act_r <= pad_act_nxt;
      if (cmd.start_comp) begin
        rnd_r <= '0;
      end else if (cmd.round_en) begin
        rnd_r <= rnd_r + 7'd1;
      end
      if (cmd.emit_clear) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= init_hash(3'(i));
        end
      end else if (cmd.finish_comp) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
    end
  end

  assign emit_word = h_r[emit_idx];

endmodule

FILE: sv/sha512_ctrl.sv
// Controller: sequences word loads, compression, padding and digest output.
module sha512_ctrl
  import sha512_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_idx,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign out_idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (sts.buf_full) begin
          state_nxt = ST_COMP;
        end else if (in_acc && in_last) begin
          state_nxt = ST_PAD;
        end
      end
      ST_COMP: begin
        if (sts.round_done) begin
          state_nxt = sts.pad_busy ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (sts.buf_full) begin
          state_nxt = ST_COMP;
        end else if (sts.pad_done) begin
          state_nxt = ST_EMIT;
          idx_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = sts.buf_full;
        cmd.start_comp = sts.buf_full;
        cmd.load_word = in_acc;
        cmd.load_last = in_acc && in_last;
      end
      ST_COMP: begin
        // after the last round, fold into the chaining value instead of running a round
        cmd.round_en = !sts.round_done;
        cmd.finish_comp = sts.round_done;
      end
      ST_PAD: begin
        cmd.start_comp = sts.buf_full;
        cmd.pad_push = !sts.buf_full && !sts.pad_done;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit_clear = out_acc && (idx_r == 3'd7);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: sv/sha512_checker.sv
// Port checker for the SHA-512 engine, bound to the top level.
module sha512_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_word_index,
  input logic       out_final_word
);

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_word == (out_word_index == 3'd7)))
    else $error("final flag mismatch");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_final_word |=> out_valid &&
    out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest index did not advance");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken during digest output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_index))
    else $error("stalled digest word changed");

endmodule

bind sha512_hash_engine sha512_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word_index(out_word_index),
  .out_final_word(out_final_word)
);
